// ===== hdl/mlpf_pkg.sv =====
// Shared constants, types and helpers of the matrix local peak finder.
package mlpf_pkg;

    localparam int MAX_COLS    = 32;
    localparam int MAX_ROWS    = 32;
    localparam int SAMPLE_BITS = 16;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CFG_W  = 6;
    localparam int CIDX_W = 1;

    localparam logic [CIDX_W-1:0] REG_FRAME_ROWS = 1'b0;
    localparam logic [CIDX_W-1:0] REG_FRAME_COLS = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic shift;
        logic insert;
    } cell_ctl_t;

    typedef struct packed {
        logic             we_lo;
        logic [COL_W-1:0] idx_lo;
        logic             val_lo;
        logic             we_hi;
        logic [COL_W-1:0] idx_hi;
        logic             val_hi;
        logic             start;
        logic             clear;
        logic             out_free;
    } flag_ctl_t;

    typedef struct packed {
        logic             busy;
        logic             emit;
        logic [COL_W-1:0] col;
        logic             last;
        logic             any_wr;
    } burst_stat_t;

    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] res;
        begin
            if (v < CFG_W'(2))
            begin
                res = CFG_W'(2);
            end
            else if (v > maxv)
            begin
                res = maxv;
            end
            else
            begin
                res = v;
            end
            return res;
        end
    endfunction

endpackage

// ===== hdl/matrix_local_peak_finder.sv =====
// Top level of the matrix local peak finder: control, comparisons and output register.
//
// The block takes one sample per cycle while its output register is free and no burst
// runs, and gives the verdict for the sample one row above as the current one is
// transferred. The previous two rows live in a chain of cells that shift by one slot
// with every transfer, new samples entering at the slot of the last column. On the
// final sample of a frame the last-row peaks are sent as a burst: the scanner visits
// one column per cycle unless a peak waits on the output, and needs no clearing pass.
module matrix_local_peak_finder
    import mlpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  sample_t            pixel_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ROW_W-1:0]   peak_row,
    output logic [COL_W-1:0]   peak_col,
    output logic               last_of_run
);

    logic [CFG_W-1:0] rows_cfg_reg;
    logic [CFG_W-1:0] cols_cfg_reg;
    logic [CFG_W-1:0] rows_eff;
    logic [CFG_W-1:0] cols_eff;
    logic [ROW_W-1:0] rows_m1;
    logic [COL_W-1:0] cols_m1;

    logic [ROW_W-1:0] r_reg;
    logic [ROW_W-1:0] r_next;
    logic [COL_W-1:0] c_reg;
    logic [COL_W-1:0] c_next;

    sample_t prev_vc_reg;
    sample_t prev1_reg;
    sample_t prev2_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [ROW_W-1:0] out_row_reg;
    logic [ROW_W-1:0] out_row_next;
    logic [COL_W-1:0] out_col_reg;
    logic [COL_W-1:0] out_col_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic        out_free;
    logic        accept;
    logic        last_col;
    logic        last_row;
    logic        pk;
    sample_t     vc;
    sample_t     uc;
    sample_t     right;
    flag_ctl_t   fctl;
    burst_stat_t fstat;

    sample_t   a_val [MAX_COLS];
    sample_t   b_val [MAX_COLS];
    cell_ctl_t cctl  [MAX_COLS];

    assign rows_eff = eff_size(rows_cfg_reg, CFG_W'(MAX_ROWS));
    assign cols_eff = eff_size(cols_cfg_reg, CFG_W'(MAX_COLS));
    assign rows_m1  = ROW_W'(rows_eff - CFG_W'(1));
    assign cols_m1  = COL_W'(cols_eff - CFG_W'(1));

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = fstat.busy || !out_free;
    assign accept   = in_valid && !in_stall;
    assign last_col = (c_reg == cols_m1);
    assign last_row = (r_reg == rows_m1);

    assign vc    = a_val[0];
    assign uc    = b_val[0];
    assign right = a_val[1];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_COLS; gi++)
        begin : g_cell
            assign cctl[gi].shift  = accept;
            assign cctl[gi].insert = (cols_m1 == COL_W'(gi));
            if (gi == MAX_COLS - 1)
            begin : g_end
                mlpf_cell u_cell
                (
                    .clk          (clk),
                    .ctl          (cctl[gi]),
                    .a_from_right (pixel_value),
                    .b_from_right (vc),
                    .a_insert     (pixel_value),
                    .b_insert     (vc),
                    .a_val        (a_val[gi]),
                    .b_val        (b_val[gi])
                );
            end
            else
            begin : g_mid
                mlpf_cell u_cell
                (
                    .clk          (clk),
                    .ctl          (cctl[gi]),
                    .a_from_right (a_val[gi+1]),
                    .b_from_right (b_val[gi+1]),
                    .a_insert     (pixel_value),
                    .b_insert     (vc),
                    .a_val        (a_val[gi]),
                    .b_val        (b_val[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        pk = (r_reg != '0) && (pixel_value <= vc);
        if ((r_reg >= ROW_W'(2)) && (uc > vc))
        begin
            pk = 1'b0;
        end
        if ((c_reg != '0) && (prev_vc_reg > vc))
        begin
            pk = 1'b0;
        end
        if (!last_col && (right > vc))
        begin
            pk = 1'b0;
        end

        fctl.we_lo    = accept && last_row && (c_reg != '0);
        fctl.idx_lo   = c_reg - COL_W'(1);
        fctl.val_lo   = (prev1_reg >= prev_vc_reg) && (prev1_reg >= pixel_value)
                        && !((c_reg >= COL_W'(2)) && (prev2_reg > prev1_reg));
        fctl.we_hi    = accept && last_row && last_col;
        fctl.idx_hi   = c_reg;
        fctl.val_hi   = (pixel_value >= vc) && (pixel_value >= prev1_reg);
        fctl.start    = accept && last_row && last_col;
        fctl.clear    = cfg_write;
        fctl.out_free = out_free;
    end

    mlpf_burst u_burst
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fctl),
        .stat  (fstat)
    );

    always_comb
    begin
        c_next = c_reg;
        r_next = r_reg;
        if (accept)
        begin
            if (last_col)
            begin
                c_next = '0;
                r_next = last_row ? '0 : r_reg + ROW_W'(1);
            end
            else
            begin
                c_next = c_reg + COL_W'(1);
            end
        end
        if (cfg_write)
        begin
            c_next = '0;
            r_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
            if (accept && pk)
            begin
                out_valid_next = 1'b1;
                out_row_next   = r_reg - ROW_W'(1);
                out_col_next   = c_reg;
                out_last_next  = !(fctl.start && fstat.any_wr);
            end
            else if (fstat.emit)
            begin
                out_valid_next = 1'b1;
                out_row_next   = rows_m1;
                out_col_next   = fstat.col;
                out_last_next  = fstat.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= CFG_W'(32);
            cols_cfg_reg  <= CFG_W'(32);
            r_reg         <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FRAME_ROWS: rows_cfg_reg <= cfg_data;
                    REG_FRAME_COLS: cols_cfg_reg <= cfg_data;
                    default:        ;
                endcase
            end
            r_reg         <= r_next;
            c_reg         <= c_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_vc_reg <= vc;
            prev1_reg   <= pixel_value;
            prev2_reg   <= prev1_reg;
        end
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign peak_row    = out_row_reg;
    assign peak_col    = out_col_reg;
    assign last_of_run = out_last_reg;

endmodule

// ===== hdl/mlpf_cell.sv =====
// One slot of the two row delay lines, holding one sample of each line.
module mlpf_cell
    import mlpf_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  sample_t   a_from_right,
    input  sample_t   b_from_right,
    input  sample_t   a_insert,
    input  sample_t   b_insert,
    output sample_t   a_val,
    output sample_t   b_val
);

    sample_t a_reg;
    sample_t b_reg;
    sample_t a_next;
    sample_t b_next;

    always_comb
    begin
        a_next = ctl.insert ? a_insert : a_from_right;
        b_next = ctl.insert ? b_insert : b_from_right;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign a_val = a_reg;
    assign b_val = b_reg;

endmodule

// ===== hdl/mlpf_burst.sv =====
// Last-row peak flags and the scanner that emits them after the final sample.
module mlpf_burst
    import mlpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  flag_ctl_t   ctl,
    output burst_stat_t stat
);

    logic [MAX_COLS-1:0] flags_reg;
    logic [MAX_COLS-1:0] flags_next;
    logic [MAX_COLS-1:0] flags_wr;
    logic [MAX_COLS-1:0] flags_left;
    logic                burst_reg;
    logic                burst_next;
    logic [COL_W-1:0]    k_reg;
    logic [COL_W-1:0]    k_next;
    logic                hit;

    always_comb
    begin
        flags_wr = flags_reg;
        if (ctl.we_lo)
        begin
            flags_wr[ctl.idx_lo] = ctl.val_lo;
        end
        if (ctl.we_hi)
        begin
            flags_wr[ctl.idx_hi] = ctl.val_hi;
        end

        hit        = burst_reg && flags_reg[k_reg];
        flags_left = flags_reg & ~(MAX_COLS'(1) << k_reg);

        flags_next = flags_reg;
        burst_next = burst_reg;
        k_next     = k_reg;
        if (ctl.clear)
        begin
            flags_next = '0;
            burst_next = 1'b0;
            k_next     = '0;
        end
        else if (ctl.start)
        begin
            flags_next = flags_wr;
            burst_next = |flags_wr;
            k_next     = '0;
        end
        else if (burst_reg)
        begin
            if (!hit || ctl.out_free)
            begin
                k_next = k_reg + COL_W'(1);
                if (hit)
                begin
                    flags_next = flags_left;
                    if (flags_left == '0)
                    begin
                        burst_next = 1'b0;
                    end
                end
            end
        end
        else
        begin
            flags_next = flags_wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            burst_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            burst_reg <= burst_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        stat.busy   = burst_reg;
        stat.emit   = hit && ctl.out_free;
        stat.col    = k_reg;
        stat.last   = (flags_left == '0);
        stat.any_wr = |flags_wr;
    end

endmodule

// ===== bench/tb_matrix_local_peak_finder.sv =====
// Self-checking testbench for the matrix local peak finder, with its own peak predictor.
`timescale 1ns / 100ps

module tb_matrix_local_peak_finder;
    import mlpf_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 24;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             is_last;
    } peak_t;

    typedef enum int {FILL_ANY, FILL_NARROW, FILL_EXTREME} fill_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_write   = 1'b0;
    logic [CIDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0] cfg_data    = '0;
    logic             in_valid    = 1'b0;
    sample_t          pixel_value = '0;
    logic             out_stall   = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic [ROW_W-1:0] peak_row;
    logic [COL_W-1:0] peak_col;
    logic             last_of_run;

    logic [CFG_W-1:0] rows_setting;
    logic [CFG_W-1:0] cols_setting;
    sample_t          older_line [MAX_COLS];
    sample_t          newer_line [MAX_COLS];
    bit               bottom_flags [MAX_COLS];
    int               next_row;
    int               next_col;

    peak_t            expected_peaks [$];
    peak_t            oldest_peak;
    int               fail_count  = 0;
    int               cycle_count = 0;
    int               stall_left  = 0;
    int               long_hold   = 0;
    bit               sender_idle   = 1'b1;
    bit               receiver_idle = 1'b1;

    matrix_local_peak_finder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .peak_row    (peak_row),
        .peak_col    (peak_col),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
        if (v < 2)
        begin
            return 2;
        end
        if (v > maxv)
        begin
            return maxv;
        end
        return int'(v);
    endfunction

    function automatic sample_t draw_sample(input fill_t fill);
        int pick;
        pick = $urandom_range(0, 4);
        case (fill)
            FILL_NARROW:
            begin
                return sample_t'(pick - 2);
            end
            FILL_EXTREME:
            begin
                case (pick)
                    0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                    1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            default:
            begin
                return sample_t'($urandom);
            end
        endcase
    endfunction

    task automatic clear_position();
        next_row = 0;
        next_col = 0;
        foreach (bottom_flags[k])
        begin
            bottom_flags[k] = 1'b0;
        end
    endtask

    task automatic predict_peaks(input sample_t cur);
        int      rows;
        int      cols;
        int      r;
        int      c;
        sample_t above;
        sample_t two_above;
        sample_t centre;
        bit      is_peak;
        peak_t   found [$];
        rows = clamp_dim(rows_setting, MAX_ROWS);
        cols = clamp_dim(cols_setting, MAX_COLS);
        if (next_row >= rows || next_col >= cols)
        begin
            clear_position();
        end
        r = next_row;
        c = next_col;
        above = newer_line[c];
        two_above = older_line[c];
        older_line[c] = above;
        newer_line[c] = cur;
        if (r >= 1)
        begin
            is_peak = (cur <= above);
            if (r >= 2 && two_above > above)
            begin
                is_peak = 1'b0;
            end
            if (c >= 1 && older_line[c-1] > above)
            begin
                is_peak = 1'b0;
            end
            if (c + 1 < cols && newer_line[c+1] > above)
            begin
                is_peak = 1'b0;
            end
            if (is_peak)
            begin
                found.push_back('{row: ROW_W'(r - 1), col: COL_W'(c), is_last: 1'b0});
            end
        end
        if (r == rows - 1)
        begin
            if (c >= 1)
            begin
                centre = newer_line[c-1];
                is_peak = (centre >= older_line[c-1]) && (centre >= cur);
                if (c >= 2 && newer_line[c-2] > centre)
                begin
                    is_peak = 1'b0;
                end
                bottom_flags[c-1] = is_peak;
            end
            if (c == cols - 1)
            begin
                bottom_flags[c] = (cur >= older_line[c]) && (cur >= newer_line[c-1]);
                for (int k = 0; k < cols; k++)
                begin
                    if (bottom_flags[k])
                    begin
                        found.push_back('{row: ROW_W'(r), col: COL_W'(k), is_last: 1'b0});
                    end
                end
            end
        end
        if (found.size() > 0)
        begin
            found[found.size()-1].is_last = 1'b1;
        end
        foreach (found[k])
        begin
            expected_peaks.push_back(found[k]);
        end
        c++;
        if (c >= cols)
        begin
            c = 0;
            r++;
        end
        if (r >= rows)
        begin
            clear_position();
        end
        else
        begin
            next_row = r;
            next_col = c;
        end
    endtask

    task automatic send_pixel(input sample_t value);
        int gap;
        gap = sender_idle ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_peaks(value);
    endtask

    task automatic send_pixels(input int count, input fill_t fill);
        for (int k = 0; k < count; k++)
        begin
            send_pixel(draw_sample(fill));
        end
    endtask

    // Waits until every predicted peak has been transferred and the burst scan has finished.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_peaks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] index, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (index == REG_FRAME_ROWS)
        begin
            rows_setting = value;
        end
        else
        begin
            cols_setting = value;
        end
        clear_position();
    endtask

    task automatic configure_frame(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        settle();
        write_reg(REG_FRAME_ROWS, rows);
        write_reg(REG_FRAME_COLS, cols);
    endtask

    task automatic apply_reset();
        rows_setting = CFG_W'(MAX_ROWS);
        cols_setting = CFG_W'(MAX_COLS);
        foreach (older_line[k])
        begin
            older_line[k] = '0;
            newer_line[k] = '0;
        end
        clear_position();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    endtask

    task automatic test_corner_ties();
        configure_frame(CFG_W'(2), CFG_W'(2));
        repeat (4) send_pixel(sample_t'(5));
    endtask

    task automatic test_value_extremes();
        configure_frame(CFG_W'(2), CFG_W'(3));
        for (int k = 0; k < 6; k++)
        begin
            send_pixel(k % 2 == 0 ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                  : {1'b1, {(SAMPLE_BITS-1){1'b0}}});
        end
        configure_frame(CFG_W'(3), CFG_W'(3));
        for (int k = 0; k < 9; k++)
        begin
            send_pixel(k == 4 ? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : sample_t'(0));
        end
    endtask

    task automatic test_size_clamping();
        configure_frame(CFG_W'(0), CFG_W'(1));
        for (int k = 1; k <= 4; k++)
        begin
            send_pixel(sample_t'(k));
        end
    endtask

    task automatic test_size_extremes();
        configure_frame(CFG_W'(63), CFG_W'(2));
        send_pixels(64, FILL_ANY);
        configure_frame(CFG_W'(2), CFG_W'(32));
        send_pixels(64, FILL_NARROW);
    endtask

    task automatic test_restart_midframe();
        configure_frame(CFG_W'(4), CFG_W'(4));
        send_pixels(7, FILL_NARROW);
        settle();
        send_pixels(3, FILL_NARROW);
        configure_frame(CFG_W'(4), CFG_W'(4));
        send_pixels(16, FILL_NARROW);
    endtask

    task automatic test_output_hold();
        configure_frame(CFG_W'(3), CFG_W'(8));
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        @(posedge clk);
        long_hold = HOLD_CYCLES;
        send_pixels(24, FILL_NARROW);
        settle();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    task automatic test_random_frames();
        int    sent;
        int    frame_len;
        int    pause_at;
        bit    restart_due;
        bit    wide;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        fill_t fill;
        sent = 0;
        restart_due = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            if (restart_due || $urandom_range(0, 2) != 0)
            begin
                wide = ($urandom_range(0, 9) == 0);
                rows = wide ? CFG_W'(2) : CFG_W'($urandom_range(2, 6));
                cols = wide ? CFG_W'($urandom_range(16, 32)) : CFG_W'($urandom_range(2, 8));
                if ($urandom_range(0, 9) == 0)
                begin
                    cols = CFG_W'($urandom_range(0, 1));
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    rows = wide ? CFG_W'($urandom_range(0, 1)) : CFG_W'($urandom_range(33, 63));
                end
                configure_frame(rows, cols);
            end
            frame_len = clamp_dim(rows_setting, MAX_ROWS) * clamp_dim(cols_setting, MAX_COLS);
            if (frame_len > 64)
            begin
                rows = CFG_W'(2);
                configure_frame(rows, cols_setting);
                frame_len = clamp_dim(rows_setting, MAX_ROWS) * clamp_dim(cols_setting, MAX_COLS);
            end
            restart_due = ($urandom_range(0, 7) == 0);
            if (restart_due)
            begin
                frame_len = $urandom_range(1, frame_len - 1);
            end
            pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, frame_len) : -1;
            fill = fill_t'($urandom_range(0, 2));
            for (int k = 0; k < frame_len; k++)
            begin
                if (k == pause_at)
                begin
                    settle();
                end
                send_pixel(draw_sample(fill));
            end
            sent += frame_len;
        end
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (long_hold > 0)
        begin
            out_stall <= 1'b1;
            long_hold--;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            stall_left = receiver_idle ? $urandom_range(0, 14) : 0;
            if (expected_peaks.size() == 0)
            begin
                $error("peak transfer with none predicted: row %0d, col %0d", peak_row, peak_col);
                fail_count++;
            end
            else
            begin
                oldest_peak = expected_peaks.pop_front();
                if (peak_row !== oldest_peak.row)
                begin
                    $error("peak_row: expected %0d, got %0d", oldest_peak.row, peak_row);
                    fail_count++;
                end
                if (peak_col !== oldest_peak.col)
                begin
                    $error("peak_col: expected %0d, got %0d", oldest_peak.col, peak_col);
                    fail_count++;
                end
                if (last_of_run !== oldest_peak.is_last)
                begin
                    $error("last_of_run: expected %0d, got %0d", oldest_peak.is_last, last_of_run);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        apply_reset();
        test_corner_ties();
        test_value_extremes();
        test_size_clamping();
        test_size_extremes();
        test_restart_midframe();
        test_output_hold();
        test_random_frames();
        settle();
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== matrix_local_peak_finder.f =====
hdl/mlpf_pkg.sv
hdl/mlpf_cell.sv
hdl/mlpf_burst.sv
hdl/matrix_local_peak_finder.sv
bench/tb_matrix_local_peak_finder.sv
